/* rtl/sgp_pkg.sv */
// sgp_pkg: shared types and constants for the stereo gain/pack pipeline.
// No dependencies.
package sgp_pkg;

  // Output format codes
  typedef enum logic [3:0] {
    FMT_S16     = 4'd0,
    FMT_S24IN32 = 4'd1,
    FMT_S24_3   = 4'd2,
    FMT_S32     = 4'd3,
    FMT_U32LE   = 4'd4,
    FMT_U32BE   = 4'd5,
    FMT_U16LE   = 4'd6,
    FMT_U16BE   = 4'd7,
    FMT_U8      = 4'd8
  } fmt_e;

  // Config register indexes
  typedef enum logic [1:0] {
    CFG_GAIN_LEFT  = 2'd0,
    CFG_GAIN_RIGHT = 2'd1,
    CFG_MONO_MODE  = 2'd2,
    CFG_OUT_FORMAT = 2'd3
  } cfg_idx_e;

  localparam int unsigned GainW = 31;
  localparam int unsigned SampW = 32;
  localparam int unsigned ProdW = 64;

  localparam logic [GainW-1:0] UnityGain = 31'd65536;
  localparam logic signed [ProdW-1:0] SatLimit = 64'sh0000_7fff_ffff_ffff;

  // Per-stage control: valid bit travels with the frame's last flag
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

/* rtl/sgp_if.sv */
// sgp_if: valid/ready channel interfaces for input frames and packed words.
// No dependencies.
interface sgp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_sample;
  logic signed [31:0] right_sample;
  logic               frame_last;

  modport source (output valid, left_sample, right_sample, frame_last, input ready);
  modport sink   (input valid, left_sample, right_sample, frame_last, output ready);
endinterface

interface sgp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_bytes;
  logic [3:0]  byte_count;
  logic        frame_end;

  modport source (output valid, packed_bytes, byte_count, frame_end, input ready);
  modport sink   (input valid, packed_bytes, byte_count, frame_end, output ready);
endinterface

/* rtl/sgp_mono.sv */
// sgp_mono: stage 1, mono mode (copy or average of the two channels).
// Depends on sgp_pkg.
module sgp_mono import sgp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ctl_t                    ctl_i,
  input  logic signed [SampW-1:0] l_i,
  input  logic signed [SampW-1:0] r_i,
  input  logic [1:0]              mono_i,
  output ctl_t                    ctl_o,
  output logic signed [SampW-1:0] l_o,
  output logic signed [SampW-1:0] r_o
);

  logic signed [SampW:0]   sum;
  logic signed [SampW:0]   sum_adj;
  logic signed [SampW-1:0] avg;
  logic signed [SampW-1:0] l_d, r_d, l_q, r_q;
  ctl_t                    ctl_q;

  // average truncated toward zero: bias negative sums by one before the shift
  assign sum     = {l_i[SampW-1], l_i} + {r_i[SampW-1], r_i};
  assign sum_adj = sum + {{SampW{1'b0}}, sum[SampW]};
  assign avg     = sum_adj[SampW:1];

  always_comb begin
    l_d = l_i;
    r_d = r_i;
    case (mono_i)
      2'd3: begin
        l_d = avg;
        r_d = avg;
      end
      2'd2: l_d = r_i;
      2'd1: r_d = l_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q <= l_d;
      r_q <= r_d;
    end
  end

  assign ctl_o = ctl_q;
  assign l_o   = l_q;
  assign r_o   = r_q;

endmodule

/* rtl/sgp_mul.sv */
// sgp_mul: stage 2, one 32x32 signed multiply per channel by the unsigned 15.16 gain.
// Depends on sgp_pkg.
module sgp_mul import sgp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ctl_t                    ctl_i,
  input  logic signed [SampW-1:0] l_i,
  input  logic signed [SampW-1:0] r_i,
  input  logic [GainW-1:0]        gain_l_i,
  input  logic [GainW-1:0]        gain_r_i,
  output ctl_t                    ctl_o,
  output logic signed [ProdW-1:0] pl_o,
  output logic signed [ProdW-1:0] pr_o,
  output logic signed [SampW-1:0] l_o,
  output logic signed [SampW-1:0] r_o
);

  logic signed [SampW-1:0] gl, gr;
  logic signed [ProdW-1:0] pl_d, pr_d, pl_q, pr_q;
  logic signed [SampW-1:0] l_q, r_q;
  ctl_t                    ctl_q;

  // gains are unsigned; a zero top bit keeps them positive as signed operands
  assign gl   = {1'b0, gain_l_i};
  assign gr   = {1'b0, gain_r_i};
  assign pl_d = ProdW'(gl) * ProdW'(l_i);
  assign pr_d = ProdW'(gr) * ProdW'(r_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
      pr_q <= pr_d;
      l_q  <= l_i;
      r_q  <= r_i;
    end
  end

  assign ctl_o = ctl_q;
  assign pl_o  = pl_q;
  assign pr_o  = pr_q;
  assign l_o   = l_q;
  assign r_o   = r_q;

endmodule

/* rtl/sgp_sat.sv */
// sgp_sat: stage 3, saturate products, floor shift by 16, pick raw for DSD.
// Depends on sgp_pkg.
module sgp_sat import sgp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ctl_t                    ctl_i,
  input  logic signed [ProdW-1:0] pl_i,
  input  logic signed [ProdW-1:0] pr_i,
  input  logic signed [SampW-1:0] l_i,
  input  logic signed [SampW-1:0] r_i,
  input  logic [3:0]              fmt_i,
  output ctl_t                    ctl_o,
  output logic [SampW-1:0]        lw_o,
  output logic [SampW-1:0]        rw_o
);

  logic signed [ProdW-1:0] sl, sr;
  logic                    pcm;
  logic [SampW-1:0]        lw_d, rw_d, lw_q, rw_q;
  ctl_t                    ctl_q;

  always_comb begin
    sl = pl_i;
    if (pl_i > SatLimit)  sl = SatLimit;
    if (pl_i < -SatLimit) sl = -SatLimit;
    sr = pr_i;
    if (pr_i > SatLimit)  sr = SatLimit;
    if (pr_i < -SatLimit) sr = -SatLimit;
  end

  // saturated value fits 48 bits, so bits 47:16 are the floor shift
  assign pcm  = (fmt_i <= FMT_S32);
  assign lw_d = pcm ? sl[47:16] : l_i;
  assign rw_d = pcm ? sr[47:16] : r_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lw_q <= lw_d;
      rw_q <= rw_d;
    end
  end

  assign ctl_o = ctl_q;
  assign lw_o  = lw_q;
  assign rw_o  = rw_q;

endmodule

/* rtl/sgp_pack.sv */
// sgp_pack: stage 4, byte packing by format into the output register.
// Depends on sgp_pkg.
module sgp_pack import sgp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  ctl_t             ctl_i,
  input  logic [SampW-1:0] lw_i,
  input  logic [SampW-1:0] rw_i,
  input  logic [3:0]       fmt_i,
  output ctl_t             ctl_o,
  output logic [63:0]      bytes_o,
  output logic [3:0]       count_o
);

  logic [SampW-1:0] ls, rs, lb, rb;
  logic [63:0]      bytes_d, bytes_q;
  logic [3:0]       count_d, count_q;
  ctl_t             ctl_q;

  assign ls = {{8{lw_i[31]}}, lw_i[31:8]};
  assign rs = {{8{rw_i[31]}}, rw_i[31:8]};
  assign lb = {lw_i[7:0], lw_i[15:8], lw_i[23:16], lw_i[31:24]};
  assign rb = {rw_i[7:0], rw_i[15:8], rw_i[23:16], rw_i[31:24]};

  always_comb begin
    bytes_d = '0;
    count_d = '0;
    case (fmt_e'(fmt_i))
      FMT_S16, FMT_U16LE: begin
        bytes_d = {32'd0, rw_i[31:16], lw_i[31:16]};
        count_d = 4'd4;
      end
      FMT_S24IN32: begin
        bytes_d = {rs, ls};
        count_d = 4'd8;
      end
      FMT_S24_3: begin
        bytes_d = {16'd0, rw_i[31:8], lw_i[31:8]};
        count_d = 4'd6;
      end
      FMT_S32, FMT_U32LE: begin
        bytes_d = {rw_i, lw_i};
        count_d = 4'd8;
      end
      FMT_U32BE: begin
        bytes_d = {rb, lb};
        count_d = 4'd8;
      end
      FMT_U16BE: begin
        bytes_d = {32'd0, rw_i[23:16], rw_i[31:24], lw_i[23:16], lw_i[31:24]};
        count_d = 4'd4;
      end
      FMT_U8: begin
        bytes_d = {48'd0, rw_i[31:24], lw_i[31:24]};
        count_d = 4'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bytes_q <= bytes_d;
      count_q <= count_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign bytes_o = bytes_q;
  assign count_o = count_q;

endmodule

/* rtl/stereo_gain_pack.sv */
// stereo_gain_pack: an accepted frame passes the mono, multiply, saturate and pack stage registers to the packed word.
// Throughput: one frame per cycle while the sink accepts words; stage 2 holds one 32x32 multiply per channel.
// Stalls: each stage loads when empty or when the one after it loads, so a
// stalled sink holds the output word and backs up the pipe without loss.
// Reset (async, active low): pipe empty, unity gains, no mono, S16 format.
// Depends on sgp_pkg, sgp_if and the four stage modules.
module stereo_gain_pack import sgp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sgp_in_if.sink     in_if,
  sgp_out_if.source  out_if,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  // ---------------------------------------------------------------
  // Configuration registers; written only while the pipe is idle (a user rule, not enforced here).
  // ---------------------------------------------------------------
  logic [GainW-1:0] gain_l_q, gain_r_q;
  logic [1:0]       mono_q;
  logic [3:0]       fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_l_q <= UnityGain;
      gain_r_q <= UnityGain;
      mono_q   <= '0;
      fmt_q    <= FMT_S16;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_LEFT:  gain_l_q <= cfg_data_i;
        CFG_GAIN_RIGHT: gain_r_q <= cfg_data_i;
        CFG_MONO_MODE:  mono_q   <= cfg_data_i[1:0];
        CFG_OUT_FORMAT: fmt_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Stall chain: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------
  ctl_t ctl_in, ctl1, ctl2, ctl3, ctl4;
  logic en1, en2, en3, en4;

  assign en4 = !ctl4.valid || out_if.ready;
  assign en3 = !ctl3.valid || en4;
  assign en2 = !ctl2.valid || en3;
  assign en1 = !ctl1.valid || en2;

  assign in_if.ready  = en1;
  assign ctl_in.valid = in_if.valid;
  assign ctl_in.last  = in_if.frame_last;

  // stage 1: mono
  logic signed [SampW-1:0] l1, r1;
  sgp_mono u_mono (
    .clk_i, .rst_ni,
    .en_i   (en1),
    .ctl_i  (ctl_in),
    .l_i    (in_if.left_sample),
    .r_i    (in_if.right_sample),
    .mono_i (mono_q),
    .ctl_o  (ctl1),
    .l_o    (l1),
    .r_o    (r1)
  );

  // stage 2: gain multiply
  logic signed [ProdW-1:0] pl2, pr2;
  logic signed [SampW-1:0] l2, r2;
  sgp_mul u_mul (
    .clk_i, .rst_ni,
    .en_i     (en2),
    .ctl_i    (ctl1),
    .l_i      (l1),
    .r_i      (r1),
    .gain_l_i (gain_l_q),
    .gain_r_i (gain_r_q),
    .ctl_o    (ctl2),
    .pl_o     (pl2),
    .pr_o     (pr2),
    .l_o      (l2),
    .r_o      (r2)
  );

  // stage 3: saturate and shift, raw bypass for DSD formats
  logic [SampW-1:0] lw3, rw3;
  sgp_sat u_sat (
    .clk_i, .rst_ni,
    .en_i  (en3),
    .ctl_i (ctl2),
    .pl_i  (pl2),
    .pr_i  (pr2),
    .l_i   (l2),
    .r_i   (r2),
    .fmt_i (fmt_q),
    .ctl_o (ctl3),
    .lw_o  (lw3),
    .rw_o  (rw3)
  );

  // stage 4: pack into the output word register
  sgp_pack u_pack (
    .clk_i, .rst_ni,
    .en_i    (en4),
    .ctl_i   (ctl3),
    .lw_i    (lw3),
    .rw_i    (rw3),
    .fmt_i   (fmt_q),
    .ctl_o   (ctl4),
    .bytes_o (out_if.packed_bytes),
    .count_o (out_if.byte_count)
  );

  assign out_if.valid     = ctl4.valid;
  assign out_if.frame_end = ctl4.last;

`ifndef ASSERT_OFF
  // a ready sink never throttles the input side
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.ready |-> in_if.ready)
    else $error("input stalled while sink ready");

  // an accepted word always lands in stage 1
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> ctl1.valid)
    else $error("accepted word lost at stage 1");

  // bytes past the byte count are zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |->
      ((out_if.byte_count != 4'd2 || out_if.packed_bytes[63:16] == '0) &&
       (out_if.byte_count != 4'd4 || out_if.packed_bytes[63:32] == '0) &&
       (out_if.byte_count != 4'd6 || out_if.packed_bytes[63:48] == '0) &&
       (out_if.byte_count != 4'd0 || out_if.packed_bytes == '0)))
    else $error("nonzero bytes beyond byte count");
`endif

endmodule
